>>> design/mp3fs_pkg.sv
// ----------------------------------------------------------------------------
// MP3 frame sync package
// Shared header record and the bitrate and sample-rate tables.
// ----------------------------------------------------------------------------
`default_nettype none

package mp3fs_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = 1;
    localparam int QCNT_BITS   = 2;

    localparam logic [1:0] VER_MPEG1 = 2'd3;

    localparam logic [17:0] COEF_V1 = 18'd144000;
    localparam logic [17:0] COEF_V2 = 18'd72000;

    localparam int NUM_BITS = 26;
    localparam int QUO_BITS = 11;
    localparam int CNT_BITS = 4;

    typedef struct packed {
        logic [15:0] pos;
        logic [7:0]  b3;
        logic [7:0]  b2;
        logic [7:0]  b1;
    } hdr_t;

    function automatic logic [8:0] kbps_lookup(input logic [1:0] ver, input logic [3:0] bri);
        logic [8:0] v;
        if (ver == VER_MPEG1) begin
            unique case (bri)
                4'd1:    v = 9'd32;
                4'd2:    v = 9'd40;
                4'd3:    v = 9'd48;
                4'd4:    v = 9'd56;
                4'd5:    v = 9'd64;
                4'd6:    v = 9'd80;
                4'd7:    v = 9'd96;
                4'd8:    v = 9'd112;
                4'd9:    v = 9'd128;
                4'd10:   v = 9'd160;
                4'd11:   v = 9'd192;
                4'd12:   v = 9'd224;
                4'd13:   v = 9'd256;
                4'd14:   v = 9'd320;
                default: v = 9'd0;
            endcase
        end else begin
            unique case (bri)
                4'd1:    v = 9'd8;
                4'd2:    v = 9'd16;
                4'd3:    v = 9'd24;
                4'd4:    v = 9'd32;
                4'd5:    v = 9'd40;
                4'd6:    v = 9'd48;
                4'd7:    v = 9'd56;
                4'd8:    v = 9'd64;
                4'd9:    v = 9'd80;
                4'd10:   v = 9'd96;
                4'd11:   v = 9'd112;
                4'd12:   v = 9'd128;
                4'd13:   v = 9'd144;
                4'd14:   v = 9'd160;
                default: v = 9'd0;
            endcase
        end
        return v;
    endfunction

    function automatic logic [15:0] hz_lookup(input logic [1:0] ver, input logic [1:0] sri);
        logic [15:0] v;
        unique case ({ver, sri})
            4'b0000: v = 16'd11025;
            4'b0001: v = 16'd12000;
            4'b0010: v = 16'd8000;
            4'b1000: v = 16'd22050;
            4'b1001: v = 16'd24000;
            4'b1010: v = 16'd16000;
            4'b1100: v = 16'd44100;
            4'b1101: v = 16'd48000;
            4'b1110: v = 16'd32000;
            default: v = 16'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

>>> design/mp3_frame_sync_header_parser_top.sv
// ----------------------------------------------------------------------------
// MP3 frame sync header parser
// Searches a byte stream for the first Layer III header after a start.
// ----------------------------------------------------------------------------
// Takes one byte per cycle. The front end tests each four-byte window and,
// for the first valid header after a start, queues it in a two-entry header
// queue; it stalls only while that queue is full. The decoder works through
// each header in order (table lookup, one multiply, eleven divide steps of its
// bit-serial frame-length divider, output load), then holds the result in an
// output register until taken; it pops the next header only after that load.
`default_nettype none

module mp3_frame_sync_header_parser_top #(
    parameter int POSITION_BITS = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,   // data_byte[7:0], start_position[23:8]
    input  wire         s_axis_tuser,   // start_flag
    input  wire         s_axis_tlast,   // last_flag
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    // sync_position[15:0], version_code[17:16], has_crc[18], bitrate_kbps[27:19],
    // sample_rate_hz[43:28], padding[44], channel_mode[46:45],
    // mode_extension[48:47], frame_bytes[59:49], zero[63:60]
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tuser    // supported
);
    import mp3fs_pkg::*;

    logic push_valid, push_ready, pop_valid, pop_ready;
    hdr_t push_data, pop_data;

    mp3fs_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .data_byte      (s_axis_tdata[7:0]),
        .start_flag     (s_axis_tuser),
        .start_position (s_axis_tdata[23:8]),
        .last_flag      (s_axis_tlast),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_data      (push_data)
    );

    mp3fs_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    mp3fs_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_data      (pop_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

>>> design/mp3fs_front.sv
// ----------------------------------------------------------------------------
// MP3 frame sync front end
// Keeps the four-byte window and position, flags the first valid header.
// ----------------------------------------------------------------------------
`default_nettype none

module mp3fs_front #(
    parameter int POSITION_BITS = 16
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   in_valid,
    output logic                  in_ready,
    input  wire  [7:0]            data_byte,
    input  wire                   start_flag,
    input  wire  [15:0]           start_position,
    input  wire                   last_flag,
    output logic                  push_valid,
    input  wire                   push_ready,
    output mp3fs_pkg::hdr_t       push_data
);
    import mp3fs_pkg::*;

    localparam int ExtBits = (POSITION_BITS > 16) ? POSITION_BITS : 16;

    logic [7:0]               win_reg [3];
    logic [7:0]               win_next [3];
    logic [1:0]               fill_reg, fill_next, fill_eff;
    logic                     armed_reg, armed_next, armed_eff;
    logic [POSITION_BITS-1:0] pos_reg, pos_next, pos_eff, sync_p;
    logic [ExtBits-1:0]       start_ext, sync_ext;
    logic                     fire, hit, hdr_ok;

    assign fire      = in_valid & push_ready;
    assign in_ready  = push_ready;
    assign start_ext = ExtBits'(start_position);
    assign fill_eff  = start_flag ? 2'd0 : fill_reg;
    assign armed_eff = start_flag | armed_reg;
    assign pos_eff   = start_flag ? start_ext[POSITION_BITS-1:0] : pos_reg;
    assign sync_p    = pos_eff - POSITION_BITS'(3);
    assign sync_ext  = ExtBits'(sync_p);

    assign hdr_ok = (win_reg[0] == 8'hFF) && (win_reg[1][7:5] == 3'b111)
                 && (win_reg[1][4:3] != 2'b01) && (win_reg[1][2:1] == 2'b01)
                 && (win_reg[2][7:4] != 4'hF) && (win_reg[2][3:2] != 2'b11);

    assign hit        = armed_eff && (fill_eff == 2'd3) && hdr_ok;
    assign push_valid = fire & hit;
    assign push_data  = '{pos: sync_ext[15:0], b3: data_byte, b2: win_reg[2], b1: win_reg[1]};

    always_comb begin
        win_next   = win_reg;
        fill_next  = fill_reg;
        armed_next = armed_reg;
        pos_next   = pos_reg;
        if (fire) begin
            if (fill_eff == 2'd3) begin
                win_next[0] = win_reg[1];
                win_next[1] = win_reg[2];
                win_next[2] = data_byte;
                fill_next   = 2'd3;
            end else begin
                unique case (fill_eff)
                    2'd0:    win_next[0] = data_byte;
                    2'd1:    win_next[1] = data_byte;
                    default: win_next[2] = data_byte;
                endcase
                fill_next = fill_eff + 2'd1;
            end
            armed_next = armed_eff & ~hit;
            pos_next   = (pos_eff != '1) ? pos_eff + POSITION_BITS'(1) : pos_eff;
            if (last_flag) begin
                fill_next = 2'd0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        win_reg <= win_next;
        if (!aresetn) begin
            fill_reg  <= 2'd0;
            armed_reg <= 1'b0;
            pos_reg   <= '0;
        end else begin
            fill_reg  <= fill_next;
            armed_reg <= armed_next;
            pos_reg   <= pos_next;
        end
    end

endmodule

`default_nettype wire

>>> design/mp3fs_queue.sv
// ----------------------------------------------------------------------------
// MP3 frame sync header queue
// Short FIFO of found headers between front end and decoder.
// ----------------------------------------------------------------------------
`default_nettype none

module mp3fs_queue (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   push_valid,
    output logic                  push_ready,
    input  mp3fs_pkg::hdr_t       push_data,
    output logic                  pop_valid,
    input  wire                   pop_ready,
    output mp3fs_pkg::hdr_t       pop_data
);
    import mp3fs_pkg::*;

    hdr_t                 mem_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_BITS-1:0] cnt_reg, cnt_next;
    logic                 do_push, do_pop;

    assign push_ready = (cnt_reg != QCNT_BITS'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid & push_ready;
    assign do_pop     = pop_valid & pop_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            cnt_reg <= cnt_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

>>> design/mp3fs_back.sv
// ----------------------------------------------------------------------------
// MP3 frame sync decoder
// Decodes a header and works out the frame length with a serial divider.
// ----------------------------------------------------------------------------
`default_nettype none

module mp3fs_back (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   pop_valid,
    output logic                  pop_ready,
    input  mp3fs_pkg::hdr_t       pop_data,
    output logic                  m_axis_tvalid,
    input  wire                   m_axis_tready,
    output logic [63:0]           m_axis_tdata,
    output logic                  m_axis_tuser
);
    import mp3fs_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t              state_reg, state_next;
    logic [15:0]         pos_reg;
    logic [1:0]          ver_reg, cm_reg, me_reg;
    logic                crc_reg, pad_reg;
    logic [8:0]          kbps_reg;
    logic [15:0]         hz_reg;
    logic [NUM_BITS-1:0] rem_reg, dsh_reg;
    logic [QUO_BITS-1:0] quo_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic [63:0]         data_reg;
    logic                user_reg, valid_reg;
    logic [17:0]         coef;
    logic [26:0]         prod;
    logic                ge, load_out;
    logic [10:0]         frame;

    assign pop_ready     = (state_reg == ST_IDLE);
    assign coef          = (ver_reg == VER_MPEG1) ? COEF_V1 : COEF_V2;
    assign prod          = 27'(kbps_reg) * 27'(coef);
    assign ge            = (rem_reg >= dsh_reg);
    assign load_out      = (state_reg == ST_OUT) && (!valid_reg || m_axis_tready);
    assign frame         = (kbps_reg == 9'd0) ? 11'd0 : quo_reg + 11'(pad_reg);
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = data_reg;
    assign m_axis_tuser  = user_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (pop_valid) state_next = ST_MUL;
            ST_MUL:  state_next = ST_DIV;
            ST_DIV:  if (cnt_reg == '0) state_next = ST_OUT;
            ST_OUT:  if (load_out) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            ST_IDLE: begin
                pos_reg  <= pop_data.pos;
                ver_reg  <= pop_data.b1[4:3];
                crc_reg  <= ~pop_data.b1[0];
                pad_reg  <= pop_data.b2[1];
                cm_reg   <= pop_data.b3[7:6];
                me_reg   <= pop_data.b3[5:4];
                kbps_reg <= kbps_lookup(pop_data.b1[4:3], pop_data.b2[7:4]);
                hz_reg   <= hz_lookup(pop_data.b1[4:3], pop_data.b2[3:2]);
            end
            ST_MUL: begin
                rem_reg <= prod[NUM_BITS-1:0];
                dsh_reg <= NUM_BITS'(hz_reg) << (QUO_BITS - 1);
                cnt_reg <= CNT_BITS'(QUO_BITS - 1);
                quo_reg <= '0;
            end
            ST_DIV: begin
                if (ge) begin
                    rem_reg <= rem_reg - dsh_reg;
                end
                quo_reg <= {quo_reg[QUO_BITS-2:0], ge};
                dsh_reg <= dsh_reg >> 1;
                cnt_reg <= cnt_reg - 1'b1;
            end
            default: begin
                if (load_out) begin
                    data_reg <= {4'd0, frame, me_reg, cm_reg, pad_reg, hz_reg,
                                 kbps_reg, crc_reg, ver_reg, pos_reg};
                    user_reg <= (ver_reg == VER_MPEG1);
                end
            end
        endcase
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (load_out) begin
                valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

>>> dv/mp3_frame_sync_header_parser_top_tb.sv
// ----------------------------------------------------------------------------
// MP3 frame sync header parser testbench
// Streams bytes into the parser and checks every reported Layer III header,
// field by field, against a cycle-free model of the search. A short table of
// directed bytes comes first: headers before any start, saturation, free
// format, a header cut by the last byte. Random buffers follow, mostly
// well-formed headers behind random junk, under several idle and stall mixes
// and one long output hold-off that backs the parser up.
// ----------------------------------------------------------------------------
module mp3_frame_sync_header_parser_top_tb;

    localparam int RUN_LIMIT   = 200000;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_WAIT  = 60;
    localparam int PHASE_WORDS = 340;
    localparam int HOLD_HDRS   = 40;

    localparam logic [1:0] VER_MPEG25 = 2'd0;
    localparam logic [1:0] VER_RESVD  = 2'd1;
    localparam logic [1:0] VER_MPEG2  = 2'd2;
    localparam logic [1:0] LAYER_III  = 2'b01;
    localparam logic [3:0] BRI_BAD    = 4'hF;
    localparam logic [1:0] SRI_BAD    = 2'b11;
    localparam logic [7:0] SYNC_BYTE  = 8'hFF;

    typedef struct packed {
        logic [15:0] sync_pos;
        logic [1:0]  version;
        logic        has_crc;
        logic [8:0]  kbps;
        logic [15:0] rate_hz;
        logic        padding;
        logic [1:0]  chan_mode;
        logic [1:0]  mode_ext;
        logic [10:0] frame_bytes;
        logic        supported;
    } mp3_hdr_t;

    typedef struct packed {
        logic [7:0]  data;
        logic        start;
        logic [15:0] pos;
        logic        last;
        int          known;
    } dir_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;

    logic [8:0]  kbps_v1 [16] = '{0, 32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224,
                                  256, 320, 0};
    logic [8:0]  kbps_v2 [16] = '{0, 8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128,
                                  144, 160, 0};
    logic [15:0] base_hz [3]  = '{44100, 48000, 32000};

    logic [7:0]  win [3] = '{0, 0, 0};
    int          win_fill = 0;
    bit          search_on = 1'b0;
    logic [15:0] next_pos = '0;

    mp3_hdr_t    hdr_due_q [$];
    mp3_hdr_t    known_hdr [3];
    dir_row_t    dir_tab [24];

    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          words_sent = 0;
    int          err_cnt = 0;
    int          cycle_cnt;
    bit          hold_armed = 1'b0;
    bit          hold_used = 1'b0;
    int          hold_left = 0;

    mp3_frame_sync_header_parser_top i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic bit find_header(input logic [7:0] b, input logic st,
                                       input logic [15:0] sp, input logic ls,
                                       output mp3_hdr_t h);
        logic [15:0] p;
        logic [1:0]  ver;
        logic [3:0]  bri;
        logic [1:0]  sri;
        int unsigned coef;
        bit          hit;
        h = '0;
        hit = 1'b0;
        if (st) begin
            win_fill = 0;
            search_on = 1'b1;
            next_pos = sp;
        end
        p = next_pos;
        if (win_fill >= 3) begin
            ver = win[1][4:3];
            bri = win[2][7:4];
            sri = win[2][3:2];
            if (search_on && win[0] == SYNC_BYTE && win[1][7:5] == 3'b111 &&
                ver != VER_RESVD && win[1][2:1] == LAYER_III &&
                bri != BRI_BAD && sri != SRI_BAD) begin
                h.sync_pos  = p - 16'd3;
                h.version   = ver;
                h.has_crc   = ~win[1][0];
                h.kbps      = (ver == mp3fs_pkg::VER_MPEG1) ? kbps_v1[bri] : kbps_v2[bri];
                h.rate_hz   = (ver == mp3fs_pkg::VER_MPEG1) ? base_hz[sri] :
                              (ver == VER_MPEG2) ? base_hz[sri] >> 1 : base_hz[sri] >> 2;
                h.padding   = win[2][1];
                h.chan_mode = b[7:6];
                h.mode_ext  = b[5:4];
                h.supported = (ver == mp3fs_pkg::VER_MPEG1);
                coef = (ver == mp3fs_pkg::VER_MPEG1) ? 144 : 72;
                if (h.kbps != 0)
                    h.frame_bytes = 11'(coef * 32'(h.kbps) * 1000 / 32'(h.rate_hz)
                                        + 32'(h.padding));
                search_on = 1'b0;
                hit = 1'b1;
            end
            win[0] = win[1];
            win[1] = win[2];
            win[2] = b;
        end else begin
            win[win_fill] = b;
            win_fill++;
        end
        if (p != 16'hFFFF)
            next_pos = p + 16'd1;
        if (ls)
            win_fill = 0;
        return hit;
    endfunction

    task automatic put_word(input logic [7:0] d, input logic st, input logic [15:0] sp,
                            input logic ls, input int known);
        mp3_hdr_t h;
        bit       hit;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {sp, d};
        s_axis_tuser  <= st;
        s_axis_tlast  <= ls;
        do @(posedge aclk); while (!s_axis_tready);
        hit = find_header(d, st, sp, ls, h);
        if (known >= 0)
            hdr_due_q.push_back(known_hdr[known]);
        else if (hit)
            hdr_due_q.push_back(h);
        words_sent++;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge aclk);
        end
    endtask

    task automatic send_buffer(input bit well_formed, input bit tight);
        logic [7:0]  seq [$];
        logic [15:0] sp;
        logic [1:0]  ver;
        logic [1:0]  lay;
        logic [2:0]  top;
        int          n_junk;
        int          last_at;
        int          r;
        bit          st;
        sp = ($urandom_range(7) == 0) ? 16'hFFFF - 16'($urandom_range(8)) : 16'($urandom);
        if (well_formed) begin
            n_junk = tight ? 0 : $urandom_range(5);
            repeat (n_junk)
                seq.push_back(($urandom_range(5) == 0) ? SYNC_BYTE : 8'($urandom));
            r = $urandom_range(15);
            ver = (r == 0) ? VER_RESVD : (r < 6) ? VER_MPEG25 : (r < 11) ? VER_MPEG2 :
                  mp3fs_pkg::VER_MPEG1;
            lay = ($urandom_range(9) == 0) ? 2'($urandom) : LAYER_III;
            top = ($urandom_range(15) == 0) ? 3'($urandom) : 3'b111;
            seq.push_back(SYNC_BYTE);
            seq.push_back({top, ver, lay, 1'($urandom)});
            seq.push_back({4'($urandom), ($urandom_range(9) == 0) ? SRI_BAD :
                           2'($urandom_range(2)), 2'($urandom)});
            seq.push_back(8'($urandom));
            if (!tight)
                repeat ($urandom_range(3)) seq.push_back(8'($urandom));
            st = tight || ($urandom_range(9) != 0);
        end else begin
            repeat ($urandom_range(1, 8))
                seq.push_back(($urandom_range(3) == 0) ? SYNC_BYTE : 8'($urandom));
            st = ($urandom_range(4) == 0);
        end
        r = $urandom_range(9);
        last_at = (r < 5) ? seq.size() - 1 : (r < 7) ? $urandom_range(seq.size() - 1) : -1;
        foreach (seq[i])
            put_word(seq[i], st && i == 0, sp, i == last_at, -1);
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endtask

    initial begin
        mp3_hdr_t want;
        mp3_hdr_t got;
        forever begin
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready) begin
                got.sync_pos    = m_axis_tdata[15:0];
                got.version     = m_axis_tdata[17:16];
                got.has_crc     = m_axis_tdata[18];
                got.kbps        = m_axis_tdata[27:19];
                got.rate_hz     = m_axis_tdata[43:28];
                got.padding     = m_axis_tdata[44];
                got.chan_mode   = m_axis_tdata[46:45];
                got.mode_ext    = m_axis_tdata[48:47];
                got.frame_bytes = m_axis_tdata[59:49];
                got.supported   = m_axis_tuser;
                if (hdr_due_q.size() == 0) begin
                    $error("header word at position %0d with none pending", got.sync_pos);
                    err_cnt++;
                end else begin
                    want = hdr_due_q.pop_front();
                    check_field("sync_position", want.sync_pos, got.sync_pos);
                    check_field("version_code", want.version, got.version);
                    check_field("has_crc", want.has_crc, got.has_crc);
                    check_field("bitrate_kbps", want.kbps, got.kbps);
                    check_field("sample_rate_hz", want.rate_hz, got.rate_hz);
                    check_field("padding", want.padding, got.padding);
                    check_field("channel_mode", want.chan_mode, got.chan_mode);
                    check_field("mode_extension", want.mode_ext, got.mode_ext);
                    check_field("frame_bytes", want.frame_bytes, got.frame_bytes);
                    check_field("supported", want.supported, got.supported);
                end
            end
            if (hold_armed && !hold_used) begin
                hold_used = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    initial begin
        for (cycle_cnt = 0; cycle_cnt < RUN_LIMIT; cycle_cnt++)
            @(posedge aclk);
        $display("mp3_frame_sync_header_parser_top_tb: FAIL");
        $finish;
    end

    initial begin
        int idle_mix  [4];
        int stall_mix [4];
        int target;
        idle_mix  = '{0, 49, 0, 22};
        stall_mix = '{0, 0, 49, 22};
        known_hdr[0] = '{sync_pos: 16'd100, version: mp3fs_pkg::VER_MPEG1, has_crc: 1'b0,
                         kbps: 9'd128, rate_hz: 16'd44100, padding: 1'b0,
                         chan_mode: 2'd1, mode_ext: 2'd2, frame_bytes: 11'd417,
                         supported: 1'b1};
        known_hdr[1] = '{sync_pos: 16'd65532, version: VER_MPEG2, has_crc: 1'b1,
                         kbps: 9'd160, rate_hz: 16'd16000, padding: 1'b1,
                         chan_mode: 2'd3, mode_ext: 2'd3, frame_bytes: 11'd721,
                         supported: 1'b0};
        known_hdr[2] = '{sync_pos: 16'd0, version: VER_MPEG25, has_crc: 1'b1,
                         kbps: 9'd0, rate_hz: 16'd12000, padding: 1'b0,
                         chan_mode: 2'd0, mode_ext: 2'd0, frame_bytes: 11'd0,
                         supported: 1'b0};
        // header before any start: ignored
        dir_tab[0]  = '{8'hFF, 1'b0, 16'd0,     1'b0, -1};
        dir_tab[1]  = '{8'hFB, 1'b0, 16'd0,     1'b0, -1};
        dir_tab[2]  = '{8'h90, 1'b0, 16'd0,     1'b0, -1};
        dir_tab[3]  = '{8'h64, 1'b0, 16'd0,     1'b0, -1};
        // MPEG-1, 128 kbps, 44.1 kHz
        dir_tab[4]  = '{8'hFF, 1'b1, 16'd100,   1'b0, -1};
        dir_tab[5]  = '{8'hFB, 1'b0, 16'd0,     1'b0, -1};
        dir_tab[6]  = '{8'h90, 1'b0, 16'd0,     1'b0, -1};
        dir_tab[7]  = '{8'h64, 1'b0, 16'd0,     1'b0, 0};
        // saturated position, MPEG-2 with CRC and padding
        dir_tab[8]  = '{8'hFF, 1'b1, 16'hFFFF,  1'b0, -1};
        dir_tab[9]  = '{8'hF2, 1'b0, 16'd0,     1'b0, -1};
        dir_tab[10] = '{8'hEA, 1'b0, 16'd0,     1'b0, -1};
        dir_tab[11] = '{8'hFF, 1'b0, 16'd0,     1'b0, 1};
        // free format MPEG-2.5
        dir_tab[12] = '{8'hFF, 1'b1, 16'd0,     1'b0, -1};
        dir_tab[13] = '{8'hE2, 1'b0, 16'd0,     1'b0, -1};
        dir_tab[14] = '{8'h04, 1'b0, 16'd0,     1'b0, -1};
        dir_tab[15] = '{8'h00, 1'b0, 16'd0,     1'b1, 2};
        // header cut by the last byte, then found after the window refills
        dir_tab[16] = '{8'hFF, 1'b1, 16'd200,   1'b0, -1};
        dir_tab[17] = '{8'hFB, 1'b0, 16'd0,     1'b0, -1};
        dir_tab[18] = '{8'h90, 1'b0, 16'd0,     1'b1, -1};
        dir_tab[19] = '{8'h64, 1'b0, 16'd0,     1'b0, -1};
        dir_tab[20] = '{8'hFF, 1'b0, 16'd0,     1'b0, -1};
        dir_tab[21] = '{8'hFB, 1'b0, 16'd0,     1'b0, -1};
        dir_tab[22] = '{8'h94, 1'b0, 16'd0,     1'b0, -1};
        dir_tab[23] = '{8'hC0, 1'b0, 16'd0,     1'b0, -1};

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_tab[i])
            put_word(dir_tab[i].data, dir_tab[i].start, dir_tab[i].pos, dir_tab[i].last,
                     dir_tab[i].known);

        foreach (idle_mix[ph]) begin
            send_idle_pct  = idle_mix[ph];
            recv_stall_pct = stall_mix[ph];
            target = words_sent + PHASE_WORDS;
            while (words_sent < target)
                send_buffer($urandom_range(4) != 0, 1'b0);
        end

        // hold the output while headers keep coming
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_armed     = 1'b1;
        repeat (HOLD_HDRS)
            send_buffer(1'b1, 1'b1);

        s_axis_tvalid <= 1'b0;
        while (hdr_due_q.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
        if (err_cnt == 0)
            $display("mp3_frame_sync_header_parser_top_tb: PASS");
        else
            $display("mp3_frame_sync_header_parser_top_tb: FAIL");
        $finish;
    end

endmodule

>>> files.f
design/mp3fs_pkg.sv
design/mp3fs_front.sv
design/mp3fs_queue.sv
design/mp3fs_back.sv
design/mp3_frame_sync_header_parser_top.sv
dv/mp3_frame_sync_header_parser_top_tb.sv
